### rtl/core/obb_overlap_test_2d_assert.svh
// Assertion macros for the overlap test block.
`ifndef OBB_OVERLAP_TEST_2D_ASSERT_SVH
`define OBB_OVERLAP_TEST_2D_ASSERT_SVH

// ante implies cons in the same cycle
`define OBB_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// ante implies cons in the next cycle
`define OBB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/obb_pkg.sv
package obb_pkg;

    localparam int TRIG_W = 16;
    localparam int UV_W   = 2 * TRIG_W - 1;
    localparam int FRAC_SH = 14;

    typedef struct packed {
        logic en2;
        logic en3;
        logic en4;
    } obb_adv_t;

    function automatic logic [14:0] qtab(input logic [5:0] idx);
        logic [14:0] v;
        unique case (idx)
            6'd0:  v = 15'd0;     6'd1:  v = 15'd804;   6'd2:  v = 15'd1606;
            6'd3:  v = 15'd2404;  6'd4:  v = 15'd3196;  6'd5:  v = 15'd3981;
            6'd6:  v = 15'd4756;  6'd7:  v = 15'd5520;  6'd8:  v = 15'd6270;
            6'd9:  v = 15'd7005;  6'd10: v = 15'd7723;  6'd11: v = 15'd8423;
            6'd12: v = 15'd9102;  6'd13: v = 15'd9760;  6'd14: v = 15'd10394;
            6'd15: v = 15'd11003; 6'd16: v = 15'd11585; 6'd17: v = 15'd12140;
            6'd18: v = 15'd12665; 6'd19: v = 15'd13160; 6'd20: v = 15'd13623;
            6'd21: v = 15'd14053; 6'd22: v = 15'd14449; 6'd23: v = 15'd14811;
            6'd24: v = 15'd15137; 6'd25: v = 15'd15426; 6'd26: v = 15'd15679;
            6'd27: v = 15'd15893; 6'd28: v = 15'd16069; 6'd29: v = 15'd16207;
            6'd30: v = 15'd16305; 6'd31: v = 15'd16364;
            default: v = 15'd16384;
        endcase
        return v;
    endfunction

    // t in 0..16384
    function automatic logic [14:0] quarter_sin(input logic [14:0] t);
        logic [5:0]  i;
        logic [8:0]  f;
        logic [14:0] lo;
        logic [9:0]  d;
        logic [19:0] prod;
        i = t[14:9];
        f = t[8:0];
        lo = qtab(i);
        d = 10'(qtab(6'(i + 6'd1)) - lo);
        prod = 20'(d) * 20'(f) + 20'd256;
        if (i >= 6'd32) begin
            return 15'd16384;
        end
        return 15'(lo + 15'(prod[19:9]));
    endfunction

    function automatic logic signed [TRIG_W-1:0] bam_sin(input logic [15:0] a);
        logic [14:0] t;
        logic [14:0] v;
        t = a[14] ? 15'(15'd16384 - {1'b0, a[13:0]}) : {1'b0, a[13:0]};
        v = quarter_sin(t);
        return a[15] ? -$signed({1'b0, v}) : $signed({1'b0, v});
    endfunction

endpackage

### rtl/core/obb_sincos.sv
module obb_sincos
    import obb_pkg::*;
#(
    parameter int ANGLE_WIDTH = 16
) (
    input  logic [ANGLE_WIDTH-1:0]    angle,
    output logic signed [TRIG_W-1:0]  sin_v,
    output logic signed [TRIG_W-1:0]  cos_v
);

    logic [15:0] a16;

    assign a16   = 16'(angle) << (16 - ANGLE_WIDTH);
    assign sin_v = bam_sin(a16);
    assign cos_v = bam_sin(16'(a16 + 16'd16384));

endmodule

### rtl/core/obb_axis.sv
module obb_axis
    import obb_pkg::*;
#(
    parameter int COORD_WIDTH = 24
) (
    input  logic                          aclk,
    input  obb_adv_t                      adv,
    input  logic signed [TRIG_W-1:0]      ax,
    input  logic signed [TRIG_W-1:0]      ay,
    input  logic signed [TRIG_W-1:0]      ca,
    input  logic signed [TRIG_W-1:0]      sa,
    input  logic signed [TRIG_W-1:0]      cb,
    input  logic signed [TRIG_W-1:0]      sb,
    input  logic signed [COORD_WIDTH:0]   dcx,
    input  logic signed [COORD_WIDTH:0]   dcy,
    input  logic signed [COORD_WIDTH-1:0] hxa,
    input  logic signed [COORD_WIDTH-1:0] hya,
    input  logic signed [COORD_WIDTH-1:0] hxb,
    input  logic signed [COORD_WIDTH-1:0] hyb,
    output logic                          sep
);

    localparam int DW   = COORD_WIDTH + TRIG_W;
    localparam int PW   = COORD_WIDTH + UV_W;
    localparam int RW   = PW + 1;
    localparam int CMPW = RW + 1;

    logic signed [UV_W-1:0]        ua_reg, va_reg, ub_reg, vb_reg;
    logic signed [DW-1:0]          d2_reg, d3_reg;
    logic signed [COORD_WIDTH-1:0] hxa_reg, hya_reg, hxb_reg, hyb_reg;
    logic signed [PW-1:0]          pa1_reg, pa2_reg, pb1_reg, pb2_reg;
    logic [RW-1:0]                 ra_reg, rb_reg;
    logic [DW-1:0]                 dabs_reg;
    logic [CMPW-1:0]               lhs, rhs;

    function automatic logic [RW-1:0] mag(input logic signed [PW-1:0] p);
        logic signed [RW-1:0] e;
        e = RW'(p);
        return p[PW-1] ? RW'(-e) : RW'(e);
    endfunction

    // stage 2: box axes against this axis, centre offset projection
    always_ff @(posedge aclk) begin
        if (adv.en2) begin
            ua_reg  <= ca * ax + sa * ay;
            va_reg  <= ca * ay - sa * ax;
            ub_reg  <= cb * ax + sb * ay;
            vb_reg  <= cb * ay - sb * ax;
            d2_reg  <= dcx * ax + dcy * ay;
            hxa_reg <= hxa;
            hya_reg <= hya;
            hxb_reg <= hxb;
            hyb_reg <= hyb;
        end
    end

    // stage 3: extents times axis terms
    always_ff @(posedge aclk) begin
        if (adv.en3) begin
            pa1_reg <= hxa_reg * ua_reg;
            pa2_reg <= hya_reg * va_reg;
            pb1_reg <= hxb_reg * ub_reg;
            pb2_reg <= hyb_reg * vb_reg;
            d3_reg  <= d2_reg;
        end
    end

    // stage 4: projected radii
    always_ff @(posedge aclk) begin
        if (adv.en4) begin
            ra_reg   <= mag(pa1_reg) + mag(pa2_reg);
            rb_reg   <= mag(pb1_reg) + mag(pb2_reg);
            dabs_reg <= d3_reg[DW-1] ? DW'(-d3_reg) : DW'(d3_reg);
        end
    end

    assign lhs = CMPW'(dabs_reg) << FRAC_SH;
    assign rhs = CMPW'(ra_reg) + CMPW'(rb_reg);
    assign sep = lhs > rhs;

endmodule

### rtl/core/obb_overlap_test_2d.sv
// channel | ports                          | beat
// --------+--------------------------------+--------------------------
// input   | s_valid s_ready s_a_* s_b_*    | one box pair
// output  | m_valid m_ready m_overlap      | one overlap flag per pair
//
// Five register stages: sine/cosine, axis terms, extent products, radii,
// compare. One pair per cycle while the output is not stalled.
// Each stage holds when the one after it is full and stalled; bubbles fill.
// aresetn clears the stage valid bits only.
module obb_overlap_test_2d
    import obb_pkg::*;
#(
    parameter int COORD_WIDTH = 24,
    parameter int ANGLE_WIDTH = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [COORD_WIDTH-1:0] s_a_center_x,
    input  logic signed [COORD_WIDTH-1:0] s_a_center_y,
    input  logic signed [COORD_WIDTH-1:0] s_a_half_w,
    input  logic signed [COORD_WIDTH-1:0] s_a_half_h,
    input  logic [ANGLE_WIDTH-1:0]        s_a_angle,
    input  logic signed [COORD_WIDTH-1:0] s_b_center_x,
    input  logic signed [COORD_WIDTH-1:0] s_b_center_y,
    input  logic signed [COORD_WIDTH-1:0] s_b_half_w,
    input  logic signed [COORD_WIDTH-1:0] s_b_half_h,
    input  logic [ANGLE_WIDTH-1:0]        s_b_angle,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_overlap
);

`include "obb_overlap_test_2d_assert.svh"

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;
    obb_adv_t adv;

    logic signed [TRIG_W-1:0]      sa_w, ca_w, sb_w, cb_w;
    logic signed [TRIG_W-1:0]      ca_reg, sa_reg, cb_reg, sb_reg;
    logic signed [TRIG_W-1:0]      nsa, nsb;
    logic signed [COORD_WIDTH:0]   dcx_reg, dcy_reg;
    logic signed [COORD_WIDTH-1:0] hxa_reg, hya_reg, hxb_reg, hyb_reg;
    logic [3:0]                    sep;
    logic                          overlap_reg;

    assign rdy5 = !v5_reg || m_ready;
    assign rdy4 = !v4_reg || rdy5;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign s_ready = rdy1;
    assign adv = '{en2: rdy2, en3: rdy3, en4: rdy4};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= s_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
            if (rdy5) v5_reg <= v4_reg;
        end
    end

    obb_sincos #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_trig_a (
        .angle(s_a_angle), .sin_v(sa_w), .cos_v(ca_w)
    );

    obb_sincos #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_trig_b (
        .angle(s_b_angle), .sin_v(sb_w), .cos_v(cb_w)
    );

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            ca_reg  <= ca_w;
            sa_reg  <= sa_w;
            cb_reg  <= cb_w;
            sb_reg  <= sb_w;
            dcx_reg <= (COORD_WIDTH+1)'(s_a_center_x) - (COORD_WIDTH+1)'(s_b_center_x);
            dcy_reg <= (COORD_WIDTH+1)'(s_a_center_y) - (COORD_WIDTH+1)'(s_b_center_y);
            hxa_reg <= s_a_half_w;
            hya_reg <= s_a_half_h;
            hxb_reg <= s_b_half_w;
            hyb_reg <= s_b_half_h;
        end
    end

    assign nsa = -sa_reg;
    assign nsb = -sb_reg;

    obb_axis #(.COORD_WIDTH(COORD_WIDTH)) u_axis0 (
        .aclk(aclk), .adv(adv), .ax(ca_reg), .ay(sa_reg),
        .ca(ca_reg), .sa(sa_reg), .cb(cb_reg), .sb(sb_reg),
        .dcx(dcx_reg), .dcy(dcy_reg),
        .hxa(hxa_reg), .hya(hya_reg), .hxb(hxb_reg), .hyb(hyb_reg), .sep(sep[0])
    );

    obb_axis #(.COORD_WIDTH(COORD_WIDTH)) u_axis1 (
        .aclk(aclk), .adv(adv), .ax(nsa), .ay(ca_reg),
        .ca(ca_reg), .sa(sa_reg), .cb(cb_reg), .sb(sb_reg),
        .dcx(dcx_reg), .dcy(dcy_reg),
        .hxa(hxa_reg), .hya(hya_reg), .hxb(hxb_reg), .hyb(hyb_reg), .sep(sep[1])
    );

    obb_axis #(.COORD_WIDTH(COORD_WIDTH)) u_axis2 (
        .aclk(aclk), .adv(adv), .ax(cb_reg), .ay(sb_reg),
        .ca(ca_reg), .sa(sa_reg), .cb(cb_reg), .sb(sb_reg),
        .dcx(dcx_reg), .dcy(dcy_reg),
        .hxa(hxa_reg), .hya(hya_reg), .hxb(hxb_reg), .hyb(hyb_reg), .sep(sep[2])
    );

    obb_axis #(.COORD_WIDTH(COORD_WIDTH)) u_axis3 (
        .aclk(aclk), .adv(adv), .ax(nsb), .ay(cb_reg),
        .ca(ca_reg), .sa(sa_reg), .cb(cb_reg), .sb(sb_reg),
        .dcx(dcx_reg), .dcy(dcy_reg),
        .hxa(hxa_reg), .hya(hya_reg), .hxb(hxb_reg), .hyb(hyb_reg), .sep(sep[3])
    );

    always_ff @(posedge aclk) begin
        if (rdy5) begin
            overlap_reg <= ~|sep;
        end
    end

    assign m_valid   = v5_reg;
    assign m_overlap = overlap_reg;

    `OBB_ASSERT_NOW(a_ready_chain, aclk, aresetn, m_ready, s_ready, "stall with sink ready")
    `OBB_ASSERT_NEXT(a_beat_taken, aclk, aresetn, s_valid && s_ready, v1_reg, "beat lost")

endmodule
